[rtl/sauvola_local_binarizer_macros.svh]
// assertion macros for the sauvola local binarizer
// expects aclk and aresetn in the scope of the module that uses them
`ifndef SAUVOLA_LOCAL_BINARIZER_MACROS_SVH
`define SAUVOLA_LOCAL_BINARIZER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SLB_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("sauvola binarizer check failed");

// next-cycle implication, checked out of reset
`define SLB_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("sauvola binarizer check failed");

`endif

[rtl/slb_pkg.sv]
// shared constants and types for the sauvola local binarizer
// no dependencies
package slb_pkg;

    // default parameter values
    localparam int DEF_MAX_WIDTH   = 2048;
    localparam int DEF_WINDOW_SIZE = 5;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 12;
    localparam int K_W        = 8;
    localparam int ROW_W      = 13;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 11;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // register reset values
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [K_W-1:0]   RST_K_FACTOR     = 8'd77;
    localparam logic [K_W-1:0]   RST_DEV_RANGE    = 8'd128;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_K_FACTOR     = 2'd2,
        CFG_DEV_RANGE    = 2'd3
    } cfg_idx_t;

endpackage

[rtl/sauvola_local_binarizer.sv]
// sauvola local binarizer top level: line store, window, threshold sequencer
// depends on slb_pkg and sauvola_local_binarizer_macros.svh
//
// Binarizes raster grey pixels against a Sauvola threshold over a clamped
// WINDOW_SIZE square window; results trail the input by WINDOW_SIZE/2 rows and
// columns, and WINDOW_SIZE/2 rows of drain items (tuser high) flush the frame.
// Items are taken one at a time. An item passes through accept, line store
// read and read-modify-write, then, per result, a window sum over the
// columns, a square root giving the standard deviation (13 bits at the
// default window) and the multiply steps. The cost is set by the
// column-at-a-time window sum and the one-bit-per-cycle square root. A
// finished result waits in the output register while the next item is taken.
module sauvola_local_binarizer #(
    parameter int MAX_WIDTH   = slb_pkg::DEF_MAX_WIDTH,
    parameter int WINDOW_SIZE = slb_pkg::DEF_WINDOW_SIZE
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [slb_pkg::PIX_W-1:0]      s_tdata,   // pixel
    input  logic                           s_tuser,   // cmd (1 = drain)
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [slb_pkg::M_TDATA_W-1:0]  m_tdata,   // out_row, out_col, foreground
    output logic                           m_tlast,   // last_of_run
    output logic                           m_tuser,   // end_of_frame
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [slb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slb_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "sauvola_local_binarizer_macros.svh"

    localparam int WS        = WINDOW_SIZE;
    localparam int HALF      = WS / 2;
    localparam int LINE_ROWS = WS - 1;
    localparam int CTR       = WS - 1 - HALF;
    localparam int PW        = slb_pkg::PIX_W;
    localparam int DIM_W     = slb_pkg::DIM_W;
    localparam int K_W       = slb_pkg::K_W;
    localparam int ROW_W     = slb_pkg::ROW_W;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W     = COL_W + 1;
    localparam int WX_W      = (CNT_W > DIM_W) ? CNT_W : DIM_W;
    localparam int SLOT_W    = $clog2(LINE_ROWS);
    localparam int J_W       = $clog2(WS);
    localparam int D_W       = $clog2(HALF + 1);
    localparam int WORD_W    = LINE_ROWS * PW;
    // arithmetic widths
    localparam int NMAX      = WS * WS;
    localparam int N_W       = $clog2(NMAX + 1);
    localparam int CS_W      = $clog2(WS * 255 + 1);
    localparam int CQ_W      = $clog2(WS * 65025 + 1);
    localparam int S_W       = $clog2(NMAX * 255 + 1);
    localparam int Q_W       = $clog2(NMAX * 65025 + 1);
    localparam int NQ_W      = N_W + Q_W;
    localparam int SS_W      = 2 * S_W;
    localparam int SD_W      = (NQ_W + 1) / 2;
    localparam int V2_W      = 2 * SD_W;
    localparam int REM_W     = SD_W + 2;
    localparam int IT_W      = $clog2(SD_W + 1);
    localparam int NN_W      = 2 * N_W;
    localparam int NR_W      = N_W + K_W;
    localparam int A1_W      = NR_W + K_W + 1;
    localparam int A2_W      = K_W + SD_W;
    localparam int A_W       = ((A1_W > A2_W) ? A1_W : A2_W) + 1;
    localparam int RHS_W     = S_W + A_W;
    localparam int DD_W      = NN_W + K_W;
    localparam int PD_W      = DD_W + PW + 1;
    localparam int LHS_W     = PD_W + 8;
    localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int CHK_W     = NQ_W + SS_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_LOAD, ST_DSEL, ST_SUM, ST_MUL1, ST_SQI, ST_SQ,
        ST_MUL2, ST_MUL3, ST_MUL4, ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [DIM_W-1:0] image_width_reg, image_height_reg;
    logic [K_W-1:0]   k_factor_reg, dev_range_reg;

    // stream position
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [SLOT_W-1:0] base_reg;

    // item being worked on
    logic [ROW_W-1:0]  it_row_reg;
    logic [COL_W-1:0]  it_col_reg;
    logic [SLOT_W-1:0] it_base_reg;
    logic [PW-1:0]     it_pix_reg;
    logic              it_drain_reg;
    logic              it_last_col_reg;

    // line store and window
    logic [WORD_W-1:0] line_store_mem [MAX_WIDTH];
    logic [WORD_W-1:0] mem_rd_reg;
    logic [PW-1:0]     win_reg [WS][WS];   // [column][row]

    // sequencer datapath
    logic [D_W-1:0]   d_reg;
    logic [J_W-1:0]   j_reg;
    logic [S_W-1:0]   s_acc_reg;
    logic [Q_W-1:0]   q_acc_reg;
    logic [N_W-1:0]   n_acc_reg;
    logic [PW-1:0]    ctr_pix_reg;
    logic [NQ_W-1:0]  nq_reg;
    logic [SS_W-1:0]  ss_reg;
    logic [NN_W-1:0]  nn_reg;
    logic [NR_W-1:0]  nr_reg;
    logic [V2_W-1:0]  v_reg;
    logic [REM_W-1:0] rem_reg;
    logic [SD_W-1:0]  root_reg;
    logic [IT_W-1:0]  it_cnt_reg;
    logic [A1_W-1:0]  a1_reg;
    logic [A2_W-1:0]  a2_reg;
    logic [DD_W-1:0]  dd_reg;
    logic [A_W-1:0]   a_reg;
    logic [LHS_W-1:0] lhs_reg;
    logic [RHS_W-1:0] rhs_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [slb_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                          m_tlast_reg;
    logic                          m_tuser_reg;

    // effective configuration
    logic [CNT_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [K_W-1:0]   rng_eff;
    logic [ROW_W-1:0] row_limit;

    always_comb begin
        if (image_width_reg == '0)
            w_eff = CNT_W'(1);
        else if (WX_W'(image_width_reg) > WX_W'(MAX_WIDTH))
            w_eff = CNT_W'(MAX_WIDTH);
        else
            w_eff = CNT_W'(image_width_reg);
        h_eff     = (image_height_reg == '0) ? DIM_W'(1) : image_height_reg;
        rng_eff   = (dev_range_reg == '0) ? K_W'(1) : dev_range_reg;
        row_limit = ROW_W'(h_eff) + ROW_W'(HALF);
    end

    // position check and advance for the offered item
    logic              restart, take, accept;
    logic [ROW_W-1:0]  r0, r1, row_adv;
    logic [COL_W-1:0]  c0, col_adv;
    logic [CNT_W-1:0]  c1;
    logic [SLOT_W-1:0] b0, base_adv;

    always_comb begin
        restart = (CNT_W'(col_reg) >= w_eff) || (row_reg >= row_limit);
        r0      = restart ? '0 : row_reg;
        c0      = restart ? '0 : col_reg;
        b0      = restart ? '0 : base_reg;
        take    = (s_tuser == (r0 >= ROW_W'(h_eff)));
        c1      = CNT_W'(c0) + CNT_W'(1);
        r1      = r0 + ROW_W'(1);
        row_adv  = r0;
        col_adv  = COL_W'(c1);
        base_adv = b0;
        if (c1 >= w_eff) begin
            col_adv = '0;
            if (r1 >= row_limit) begin
                row_adv  = '0;
                base_adv = '0;
            end else begin
                row_adv  = r1;
                base_adv = (b0 == SLOT_W'(LINE_ROWS - 1)) ? '0 : b0 + SLOT_W'(1);
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // rows of the window that fall inside the frame
    logic [WS-1:0]  row_ok;
    logic [N_W-1:0] nrows;

    always_comb begin
        nrows = '0;
        for (int i = 0; i < WS; i++) begin
            row_ok[i] = ((ROW_W+1)'(it_row_reg) + (ROW_W+1)'(i) >= (ROW_W+1)'(WS - 1)) &&
                        ((ROW_W+1)'(it_row_reg) + (ROW_W+1)'(i) <
                         (ROW_W+1)'(h_eff) + (ROW_W+1)'(WS - 1));
            nrows = nrows + N_W'(row_ok[i]);
        end
    end

    // sum and square sum of window column j over the rows in frame
    logic [CS_W-1:0] col_sum;
    logic [CQ_W-1:0] col_sq;
    logic [15:0]     pix_sq [WS];

    always_comb begin
        col_sum = '0;
        col_sq  = '0;
        for (int i = 0; i < WS; i++) begin
            pix_sq[i] = {8'b0, win_reg[j_reg][i]} * {8'b0, win_reg[j_reg][i]};
            if (row_ok[i]) begin
                col_sum = col_sum + CS_W'(win_reg[j_reg][i]);
                col_sq  = col_sq + CQ_W'(pix_sq[i]);
            end
        end
    end

    // new window column from the line store word, and the word written back
    logic [PW-1:0]     new_col [WS];
    logic [WORD_W-1:0] wr_word;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot_idx [LINE_ROWS];

    always_comb begin
        for (int i = 0; i < LINE_ROWS; i++) begin
            slot_sum = (SLOT_W+1)'(it_base_reg) + (SLOT_W+1)'(i);
            if (slot_sum >= (SLOT_W+1)'(LINE_ROWS))
                slot_sum = slot_sum - (SLOT_W+1)'(LINE_ROWS);
            slot_idx[i] = SLOT_W'(slot_sum);
            new_col[i]  = mem_rd_reg[slot_idx[i]*PW +: PW];
        end
        new_col[WS-1] = it_drain_reg ? '0 : it_pix_reg;
        wr_word = mem_rd_reg;
        wr_word[it_base_reg*PW +: PW] = it_pix_reg;
    end

    // per-result control
    logic [D_W-1:0]   dmax;
    logic             cc_neg, col_ok, is_ctr, is_last, out_free, out_load;
    logic [CNT_W-1:0] cc;
    logic [ROW_W-1:0] rr;

    always_comb begin
        dmax    = it_last_col_reg ? D_W'(HALF) : '0;
        cc_neg  = (CNT_W'(it_col_reg) + CNT_W'(d_reg)) < CNT_W'(HALF);
        col_ok  = (CNT_W'(it_col_reg) + CNT_W'(j_reg)) >= CNT_W'(WS - 1);
        is_ctr  = (j_reg == J_W'(CTR) + J_W'(d_reg));
        is_last = (d_reg == dmax);
        cc      = CNT_W'(it_col_reg) + CNT_W'(d_reg) - CNT_W'(HALF);
        rr      = it_row_reg - ROW_W'(HALF);
        out_free = !m_tvalid_reg || m_tready;
        out_load = (state_reg == ST_EMIT) && out_free;
    end

    // square root step
    logic [REM_W-1:0] rem_sh, trial;
    assign rem_sh = {rem_reg[REM_W-3:0], v_reg[V2_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    // line store: read, then write back with the new pixel
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && !it_drain_reg)
            line_store_mem[it_col_reg] <= wr_word;
        mem_rd_reg <= line_store_mem[it_col_reg];
    end

    // sequencer, datapath and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            image_width_reg  <= slb_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= slb_pkg::RST_IMAGE_HEIGHT;
            k_factor_reg     <= slb_pkg::RST_K_FACTOR;
            dev_range_reg    <= slb_pkg::RST_DEV_RANGE;
            row_reg          <= '0;
            col_reg          <= '0;
            base_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
            for (int c = 0; c < WS; c++)
                for (int r = 0; r < WS; r++)
                    win_reg[c][r] <= '0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                unique case (slb_pkg::cfg_idx_t'(cfg_index))
                    slb_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                    slb_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                    slb_pkg::CFG_K_FACTOR:     k_factor_reg     <= cfg_data[K_W-1:0];
                    slb_pkg::CFG_DEV_RANGE:    dev_range_reg    <= cfg_data[K_W-1:0];
                    default: ;
                endcase
            end

            // result taken and no new one loaded this cycle
            if (m_tvalid_reg && m_tready && !out_load)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        row_reg  <= take ? row_adv : r0;
                        col_reg  <= take ? col_adv : c0;
                        base_reg <= take ? base_adv : b0;
                        it_row_reg      <= r0;
                        it_col_reg      <= c0;
                        it_base_reg     <= b0;
                        it_pix_reg      <= s_tdata;
                        it_drain_reg    <= s_tuser;
                        it_last_col_reg <= (CNT_W'(c0) == w_eff - CNT_W'(1));
                        if (take)
                            state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    // shift the window one column and enter the new one
                    for (int c = 0; c < WS - 1; c++)
                        for (int r = 0; r < WS; r++)
                            win_reg[c][r] <= win_reg[c+1][r];
                    for (int r = 0; r < WS; r++)
                        win_reg[WS-1][r] <= new_col[r];
                    d_reg <= '0;
                    state_reg <= (it_row_reg >= ROW_W'(HALF)) ? ST_DSEL : ST_IDLE;
                end
                ST_DSEL: begin
                    if (cc_neg) begin
                        if (is_last)
                            state_reg <= ST_IDLE;
                        else
                            d_reg <= d_reg + D_W'(1);
                    end else begin
                        s_acc_reg <= '0;
                        q_acc_reg <= '0;
                        n_acc_reg <= '0;
                        j_reg     <= J_W'(d_reg);
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    // one window column per cycle
                    if (col_ok) begin
                        s_acc_reg <= s_acc_reg + S_W'(col_sum);
                        q_acc_reg <= q_acc_reg + Q_W'(col_sq);
                        n_acc_reg <= n_acc_reg + nrows;
                    end
                    if (is_ctr)
                        ctr_pix_reg <= win_reg[j_reg][CTR];
                    if (j_reg == J_W'(WS - 1))
                        state_reg <= ST_MUL1;
                    else
                        j_reg <= j_reg + J_W'(1);
                end
                ST_MUL1: begin
                    nq_reg <= NQ_W'(n_acc_reg) * NQ_W'(q_acc_reg);
                    ss_reg <= SS_W'(s_acc_reg) * SS_W'(s_acc_reg);
                    nn_reg <= NN_W'(n_acc_reg) * NN_W'(n_acc_reg);
                    nr_reg <= NR_W'(n_acc_reg) * NR_W'(rng_eff);
                    state_reg <= ST_SQI;
                end
                ST_SQI: begin
                    v_reg      <= V2_W'(CHK_W'(nq_reg) - CHK_W'(ss_reg));
                    rem_reg    <= '0;
                    root_reg   <= '0;
                    it_cnt_reg <= '0;
                    state_reg  <= ST_SQ;
                end
                ST_SQ: begin
                    // one root bit per cycle
                    v_reg <= v_reg << 2;
                    if (rem_sh >= trial) begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[SD_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[SD_W-2:0], 1'b0};
                    end
                    if (it_cnt_reg == IT_W'(SD_W - 1))
                        state_reg <= ST_MUL2;
                    else
                        it_cnt_reg <= it_cnt_reg + IT_W'(1);
                end
                ST_MUL2: begin
                    a1_reg <= A1_W'(nr_reg) * A1_W'((K_W+1)'(256) - (K_W+1)'(k_factor_reg));
                    a2_reg <= A2_W'(k_factor_reg) * A2_W'(root_reg);
                    dd_reg <= DD_W'(nn_reg) * DD_W'(rng_eff);
                    state_reg <= ST_MUL3;
                end
                ST_MUL3: begin
                    a_reg   <= A_W'(a1_reg) + A_W'(a2_reg);
                    lhs_reg <= {PD_W'(PD_W'(ctr_pix_reg) + PD_W'(1)) * PD_W'(dd_reg), 8'b0};
                    state_reg <= ST_MUL4;
                end
                ST_MUL4: begin
                    rhs_reg   <= RHS_W'(s_acc_reg) * RHS_W'(a_reg);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {(CMP_W'(lhs_reg) <= CMP_W'(rhs_reg)),
                                         slb_pkg::OUT_COL_W'(cc),
                                         slb_pkg::OUT_ROW_W'(rr)};
                        m_tlast_reg  <= is_last;
                        m_tuser_reg  <= is_last && it_last_col_reg &&
                                        (rr == ROW_W'(h_eff) - ROW_W'(1));
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            d_reg     <= d_reg + D_W'(1);
                            state_reg <= ST_DSEL;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `SLB_ASSERT_IMPL(a_out_not_overwritten, out_load, !m_tvalid_reg || m_tready)
    `SLB_ASSERT_IMPL(a_window_count_nonzero, state_reg == ST_MUL1, n_acc_reg != '0)
    `SLB_ASSERT_IMPL(a_sqrt_floor, state_reg == ST_MUL2, (CHK_W'(root_reg) * CHK_W'(root_reg) <= CHK_W'(nq_reg) - CHK_W'(ss_reg)) && ((CHK_W'(root_reg) + CHK_W'(1)) * (CHK_W'(root_reg) + CHK_W'(1)) > CHK_W'(nq_reg) - CHK_W'(ss_reg)))
    `SLB_ASSERT_NEXT(a_taken_item_reads, accept && take, state_reg == ST_RD)
    `SLB_ASSERT_IMPL(a_item_row_in_range, state_reg == ST_RD, it_row_reg < row_limit)

endmodule
